[design/bamr_pkg.sv]
// Shared types and constants of the BAM transport reassembler.
// No dependencies; compile first.
package bamr_pkg;

	localparam int unsigned MAX_BYTES_DEF = 256;
	localparam int unsigned PKT_BYTES     = 7;
	localparam int unsigned CHUNK_BYTES   = 8;
	localparam int unsigned POS_W         = 11;

	localparam logic [17:0] PGN_CM   = 18'h0EC00;
	localparam logic [17:0] PGN_DT   = 18'h0EB00;
	localparam logic [7:0]  PDU2_MIN = 8'd240;

	typedef struct packed {
		logic [28:0] frame_id;
		logic [7:0]  byte_0;
		logic [7:0]  byte_1;
		logic [7:0]  byte_2;
		logic [7:0]  byte_3;
		logic [7:0]  byte_4;
		logic [7:0]  byte_5;
		logic [7:0]  byte_6;
		logic [7:0]  byte_7;
	} in_item_t;

	typedef struct packed {
		logic        complete;
		logic [28:0] msg_identifier;
		logic [8:0]  msg_length;
		logic [7:0]  chunk_0;
		logic [7:0]  chunk_1;
		logic [7:0]  chunk_2;
		logic [7:0]  chunk_3;
		logic [7:0]  chunk_4;
		logic [7:0]  chunk_5;
		logic [7:0]  chunk_6;
		logic [7:0]  chunk_7;
		logic        last_chunk;
	} out_item_t;

	// One row write into the byte store: per-byte enables over an 8-byte row.
	typedef struct packed {
		logic        en;
		logic [7:0]  be;
		logic [63:0] data;
	} mem_wr_t;

endpackage

[design/bamr_if.sv]
// Valid/ready channel interfaces for frames in and results out.
// Depends on bamr_pkg.
interface bamr_in_if;
	logic               valid;
	logic               ready;
	bamr_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bamr_out_if;
	logic                valid;
	logic                ready;
	bamr_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[design/bam_transport_reassembler_top.sv]
// BAM transport reassembler, top level: sequencer, byte store, result register.
// Depends on bamr_pkg, bamr_if, bamr_store, bamr_seq.
//
// Takes one extended CAN frame per beat and answers each with one status beat,
// or, once every announced packet is in, with the rebuilt message in 8-byte
// chunk beats, the last one marked. One frame is handled at a time. After reset
// and after each announcement the store and the seen map are swept clean, one
// row a cycle over the larger of the store's rows and the seen map's 32 rows;
// after an announcement its status beat follows. A data frame is accepted, its
// sequence number looked up in the seen map, a new packet's seven bytes written
// one at a time through the single byte-wide write path, and then, unless the
// message is complete, its status beat follows. A completing frame reads out
// each chunk as a row read, then a load into the result register, up to 32
// chunks at the default size. Frame ready is low for that whole time; the result
// register lets the next frame in while the final beat still waits to be taken.
module bam_transport_reassembler_top #(
	parameter int unsigned MAX_BYTES = bamr_pkg::MAX_BYTES_DEF
) (
	input logic       clk,
	input logic       arst_n,
	bamr_in_if.sink   frame,
	bamr_out_if.source result
);
	import bamr_pkg::*;

	localparam int unsigned ROWS  = (MAX_BYTES + 7) / 8;
	localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

	mem_wr_t          mem_wr;
	logic [ROW_W-1:0] wr_row;
	logic             rd_en;
	logic [ROW_W-1:0] rd_row;
	logic [63:0]      rd_data;
	logic             res_busy;
	logic             res_load;
	out_item_t        res;
	logic             res_valid_q;
	out_item_t        res_q;

	bamr_seq #(.MAX_BYTES(MAX_BYTES)) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.frame    (frame),
		.res_busy (res_busy),
		.res_load (res_load),
		.res      (res),
		.mem_wr   (mem_wr),
		.wr_row   (wr_row),
		.rd_en    (rd_en),
		.rd_row   (rd_row),
		.rd_data  (rd_data)
	);

	bamr_store #(.MAX_BYTES(MAX_BYTES)) u_store (
		.clk     (clk),
		.mem_wr  (mem_wr),
		.wr_row  (wr_row),
		.rd_en   (rd_en),
		.rd_row  (rd_row),
		.rd_data (rd_data)
	);

	// hold a beat until taken; refill in the cycle it leaves
	assign res_busy = res_valid_q && !result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> !res_busy)
		else $error("result loaded over a beat not yet taken");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && !res.complete) |-> (res.last_chunk && res.msg_identifier == 29'd0
			&& res.msg_length == 9'd0))
		else $error("status beat malformed");

	a_busy_after_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(frame.valid && frame.ready) |=> !frame.ready)
		else $error("frame accepted while previous one in progress");

	a_no_load_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(frame.valid && frame.ready) |-> !res_load)
		else $error("result loaded in the frame accept cycle");

endmodule

[design/bamr_store.sv]
// Byte store: rows of 8 bytes, one row write with byte enables and one
// registered row read per cycle. Depends on bamr_pkg.
module bamr_store #(
	parameter int unsigned MAX_BYTES = bamr_pkg::MAX_BYTES_DEF,
	localparam int unsigned ROWS  = (MAX_BYTES + 7) / 8,
	localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  logic              clk,
	input  bamr_pkg::mem_wr_t mem_wr,
	input  logic [ROW_W-1:0]  wr_row,
	input  logic              rd_en,
	input  logic [ROW_W-1:0]  rd_row,
	output logic [63:0]       rd_data
);
	import bamr_pkg::*;

	logic [63:0] mem [ROWS];

	always_ff @(posedge clk) begin
		if (mem_wr.en) begin
			for (int l = 0; l < 8; l++) begin
				if (mem_wr.be[l]) begin
					mem[wr_row][l*8 +: 8] <= mem_wr.data[l*8 +: 8];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_row];
		end
	end

endmodule

[design/bamr_seq.sv]
// Sequencer of the reassembler: announcement and packet state, seen map, clear
// sweep, byte-at-a-time packet writes and chunk readout. Depends on bamr_pkg, bamr_if.
module bamr_seq #(
	parameter int unsigned MAX_BYTES = bamr_pkg::MAX_BYTES_DEF,
	localparam int unsigned ROWS  = (MAX_BYTES + 7) / 8,
	localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	bamr_in_if.sink             frame,
	input  logic                res_busy,
	output logic                res_load,
	output bamr_pkg::out_item_t res,
	output bamr_pkg::mem_wr_t   mem_wr,
	output logic [ROW_W-1:0]    wr_row,
	output logic                rd_en,
	output logic [ROW_W-1:0]    rd_row,
	input  logic [63:0]         rd_data
);
	import bamr_pkg::*;

	localparam int unsigned LEN_W     = $clog2(MAX_BYTES + 1);
	localparam int unsigned SEEN_ROWS = 32;
	localparam int unsigned CLR_ROWS  = (ROWS > SEEN_ROWS) ? ROWS : SEEN_ROWS;
	localparam int unsigned CLR_W     = $clog2(CLR_ROWS);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_WRITE,
		S_STATUS,
		S_RD,
		S_LOAD
	} state_t;

	state_t           state_q;
	logic             post_q;
	logic [ROW_W-1:0] row_q;
	logic [CLR_W-1:0] clr_q;
	logic [7:0]       seen_mem [SEEN_ROWS];
	logic [7:0]       seen_rd_q;
	logic [7:0]       seq_q;
	logic [7:0]       frames_q;
	logic [7:0]       expected_q;
	logic [LEN_W-1:0] length_q;
	logic [17:0]      pgn_q;
	logic [7:0]       sa_q;
	logic [2:0]       prio_q;
	logic             announced_q;
	logic [POS_W-1:0] pos_q;
	logic [2:0]       cnt_q;
	logic [55:0]      data_q;

	logic [17:0]      pgn;
	logic [7:0]       seqn;
	logic [7:0]       seqm1;
	logic             take;
	logic             done_now;
	logic [15:0]      len_in;
	logic [LEN_W-1:0] len_sat;
	logic [POS_W-1:0] len_m1;
	logic [ROW_W-1:0] last_row;
	logic [7:0]       id_ps;

	always_comb begin
		pgn = frame.data.frame_id[25:8];
		if (frame.data.frame_id[23:16] < PDU2_MIN) begin
			pgn[7:0] = 8'h00;
		end
		seqn     = frame.data.byte_0;
		seqm1    = seq_q - 8'd1;
		take     = (seq_q != 8'd0) && !seen_rd_q[seq_q[2:0]] && (seq_q <= expected_q);
		done_now = announced_q && (frames_q == expected_q);
		len_in   = {frame.data.byte_2, frame.data.byte_1};
		len_sat  = (len_in > 16'(MAX_BYTES)) ? LEN_W'(MAX_BYTES) : len_in[LEN_W-1:0];
		len_m1   = POS_W'(length_q) - POS_W'(1);
		last_row = (length_q == '0) ? '0 : len_m1[ROW_W+2:3];
	end

	assign frame.ready = (state_q == S_IDLE);

	// seen map: 8 sequence numbers per row, swept clean with the byte store
	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR && 32'(clr_q) < SEEN_ROWS) begin
			seen_mem[clr_q[4:0]] <= 8'h00;
		end else if (state_q == S_CHECK && take) begin
			seen_mem[seq_q[7:3]][seq_q[2:0]] <= 1'b1;
		end
		if (frame.valid && frame.ready) begin
			seen_rd_q <= seen_mem[seqn[7:3]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			post_q      <= 1'b0;
			row_q       <= '0;
			clr_q       <= '0;
			seq_q       <= '0;
			frames_q    <= '0;
			expected_q  <= '0;
			length_q    <= '0;
			pgn_q       <= '0;
			sa_q        <= '0;
			prio_q      <= '0;
			announced_q <= 1'b0;
			pos_q       <= '0;
			cnt_q       <= '0;
			data_q      <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (clr_q == CLR_W'(CLR_ROWS - 1)) begin
						clr_q   <= '0;
						state_q <= post_q ? S_STATUS : S_IDLE;
					end else begin
						clr_q <= clr_q + CLR_W'(1);
					end
				end
				S_IDLE: begin
					if (frame.valid) begin
						if (pgn == PGN_CM) begin
							frames_q    <= '0;
							length_q    <= len_sat;
							expected_q  <= frame.data.byte_3;
							pgn_q       <= {frame.data.byte_7[1:0], frame.data.byte_6,
								frame.data.byte_5};
							sa_q        <= frame.data.frame_id[7:0];
							prio_q      <= frame.data.frame_id[28:26];
							announced_q <= 1'b1;
							post_q      <= 1'b1;
							clr_q       <= '0;
							state_q     <= S_CLEAR;
						end else if (pgn == PGN_DT) begin
							// hold the packet while its seen bit is read
							seq_q   <= seqn;
							data_q  <= {frame.data.byte_7, frame.data.byte_6,
								frame.data.byte_5, frame.data.byte_4, frame.data.byte_3,
								frame.data.byte_2, frame.data.byte_1};
							state_q <= S_CHECK;
						end else begin
							state_q <= S_STATUS;
						end
					end
				end
				S_CHECK: begin
					if (take) begin
						frames_q <= frames_q + 8'd1;
						pos_q    <= {seqm1, 3'b000} - {3'b000, seqm1};
						cnt_q    <= '0;
						state_q  <= S_WRITE;
					end else if (done_now) begin
						row_q   <= '0;
						state_q <= S_RD;
					end else begin
						state_q <= S_STATUS;
					end
				end
				S_WRITE: begin
					// advance one packet byte per cycle
					pos_q  <= pos_q + POS_W'(1);
					cnt_q  <= cnt_q + 3'd1;
					data_q <= data_q >> 8;
					if (cnt_q == 3'(PKT_BYTES - 1)) begin
						row_q   <= '0;
						state_q <= done_now ? S_RD : S_STATUS;
					end
				end
				S_STATUS: begin
					if (!res_busy) begin
						state_q <= S_IDLE;
					end
				end
				S_RD: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (!res_busy) begin
						if (row_q == last_row) begin
							state_q <= S_IDLE;
						end else begin
							row_q   <= row_q + ROW_W'(1);
							state_q <= S_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		mem_wr = '0;
		wr_row = row_q;
		case (state_q)
			S_CLEAR: begin
				mem_wr.en = (32'(clr_q) < ROWS);
				mem_wr.be = 8'hFF;
				wr_row    = clr_q[ROW_W-1:0];
			end
			S_WRITE: begin
				// drop bytes past the announced length
				mem_wr.en   = (pos_q < POS_W'(length_q));
				mem_wr.be   = 8'h01 << pos_q[2:0];
				mem_wr.data = {8{data_q[7:0]}};
				wr_row      = pos_q[ROW_W+2:3];
			end
			default: begin
				mem_wr = '0;
			end
		endcase
	end

	assign rd_en  = (state_q == S_RD);
	assign rd_row = row_q;

	assign id_ps = (pgn_q[15:8] < PDU2_MIN) ? 8'h00 : pgn_q[7:0];

	always_comb begin
		res      = '0;
		res_load = 1'b0;
		case (state_q)
			S_STATUS: begin
				res_load       = !res_busy;
				res.last_chunk = 1'b1;
			end
			S_LOAD: begin
				res_load           = !res_busy;
				res.complete       = 1'b1;
				res.msg_identifier = {prio_q, 1'b0, pgn_q[16], pgn_q[15:8], id_ps, sa_q};
				res.msg_length     = 9'(length_q);
				res.chunk_0        = rd_data[7:0];
				res.chunk_1        = rd_data[15:8];
				res.chunk_2        = rd_data[23:16];
				res.chunk_3        = rd_data[31:24];
				res.chunk_4        = rd_data[39:32];
				res.chunk_5        = rd_data[47:40];
				res.chunk_6        = rd_data[55:48];
				res.chunk_7        = rd_data[63:56];
				res.last_chunk     = (row_q == last_row);
			end
			default: begin
				res      = '0;
				res_load = 1'b0;
			end
		endcase
	end

endmodule
